// File: sv/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg: shared types and constants of the weighted slice statistics core
// Holds the sequencer state encoding and the fixed field widths.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int XW   = 16;
  localparam int WW   = 16;
  localparam int SUMW = 40;
  localparam int TOTW = 24;
  localparam int SPW  = 64;

  localparam logic [TOTW-1:0] TOTAL_MAX = {TOTW{1'b1}};

  typedef enum logic [9:0] {
    ST_COLLECT = 10'b0000000001,
    ST_MEAN    = 10'b0000000010,
    ST_MEANFIX = 10'b0000000100,
    ST_SPREAD  = 10'b0000001000,
    ST_SPDRAIN = 10'b0000010000,
    ST_QDIV    = 10'b0000100000,
    ST_SQRT    = 10'b0001000000,
    ST_ERRM    = 10'b0010000000,
    ST_ERRS    = 10'b0100000000,
    ST_EMIT    = 10'b1000000000
  } state_t;

endpackage

// File: sv/wss_divider.sv
// ----------------------------------------------------------------------------
// wss_divider: restoring divider, one quotient bit per cycle
// Divides a 64-bit unsigned numerator by a 24-bit unsigned denominator.
// ----------------------------------------------------------------------------
module wss_divider
  import wss_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [SPW-1:0]  num,
  input  logic [TOTW-1:0] den,
  output logic            done,
  output logic [SPW-1:0]  quo
);

  logic [SPW-1:0]  q;
  logic [TOTW:0]   rem;
  logic [TOTW-1:0] d;
  logic [6:0]      cnt;
  logic            run;
  logic [TOTW+1:0] trial;
  logic [TOTW+1:0] diff;

  assign trial = {rem, q[SPW-1]};
  assign diff  = trial - {2'b00, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 7'd0;
        q   <= num;
        rem <= '0;
        d   <= den;
      end else if (run) begin
        // shift in one numerator bit, subtract when it fits
        if (trial >= {2'b00, d}) begin
          rem <= diff[TOTW:0];
          q   <= {q[SPW-2:0], 1'b1};
        end else begin
          rem <= trial[TOTW:0];
          q   <= {q[SPW-2:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'(SPW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;

endmodule

// File: sv/weighted_slice_statistics_core.sv
// ----------------------------------------------------------------------------
// weighted_slice_statistics_core: weighted mean and sigma of a histogram slice
// Stores the pairs of one slice, then runs a second pass and fixed-point
// divides and roots to give mean, sigma and their errors.
// ----------------------------------------------------------------------------
// Pairs are taken one per cycle while collecting (busy low). A pair with last
// high ends the slice; busy then rises and the block runs: a mean divide, a
// pass over the stored pairs (one pair a cycle, plus a drain), a divide of
// the spread by the total, a 32-step square root for sigma, and two 16-step
// root searches for the errors, each followed by a rounding step. The result
// word shows for one cycle with valid high; the receiver cannot stall it.
// Pairs beyond SLICE_DEPTH are dropped and reported through overflow. The
// pair memories need no clearing after reset.
// ----------------------------------------------------------------------------
module weighted_slice_statistics_core
  import wss_pkg::*;
#(
  parameter int SLICE_DEPTH = 256
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [XW-1:0]   x_value,
  input  logic [WW-1:0]          weight,
  input  logic                   last,
  output logic                   valid,
  output logic signed [15:0]     mean,
  output logic [TOTW-1:0]        entries,
  output logic signed [15:0]     peak_x,
  output logic [15:0]            peak_y,
  output logic [15:0]            sigma,
  output logic signed [SUMW-1:0] weighted_sum,
  output logic [15:0]            mean_error,
  output logic [15:0]            sigma_error,
  output logic                   empty_slice,
  output logic                   overflow
);

  localparam int AW = $clog2(SLICE_DEPTH);
  localparam int CW = $clog2(SLICE_DEPTH + 1);

  // pair memories, one synchronous read port each
  logic [XW-1:0] pos_mem [SLICE_DEPTH];
  logic [WW-1:0] wgt_mem [SLICE_DEPTH];
  logic [XW-1:0] pos_rd;
  logic [WW-1:0] wgt_rd;
  logic [AW-1:0] rd_addr;

  state_t state;

  logic [CW-1:0]         count;
  logic [SUMW-1:0]       sum_acc;
  logic [TOTW-1:0]       total;
  logic [WW-1:0]         best_w;
  logic [XW-1:0]         best_x;
  logic [SPW-1:0]        spread;
  logic                  dropped;
  logic signed [15:0]    mean_r;
  logic [CW-1:0]         idx;
  logic                  rd_vld;
  logic                  mul_vld;
  logic [33:0]           d2;
  logic [TOTW-1:0]       e_den;
  logic [SUMW-1:0]       mag;
  logic                  neg;
  logic [16:0]           sig;
  logic [5:0]            bitn;
  logic [31:0]           root;
  logic [63:0]           qv;
  logic [15:0]           errr;
  logic [2:0]            sub;
  logic [63:0]           prod;
  logic [63:0]           prod2;
  logic                  ph2;

  logic                  accept;
  logic                  store_ok;
  logic signed [31:0]    xw;
  logic [TOTW:0]         tot_add;

  // divider shared by the mean and the spread quotient
  logic                  dv_go;
  logic [SPW-1:0]        dv_num;
  logic [TOTW-1:0]       dv_den;
  logic                  dv_done;
  logic [SPW-1:0]        dv_quo;

  wss_divider u_div (
    .clk (clk), .rst (rst), .go (dv_go), .num (dv_num), .den (dv_den),
    .done (dv_done), .quo (dv_quo)
  );

  assign busy     = (state != ST_COLLECT);
  assign accept   = start && !busy;
  assign store_ok = (count < CW'(SLICE_DEPTH));
  assign xw       = x_value * $signed({1'b0, weight});
  assign tot_add  = {1'b0, total} + {{(TOTW-WW+1){1'b0}}, weight};

  // write on an accepted pair while there is room, read during the spread pass
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      pos_mem[count[AW-1:0]] <= x_value;
      wgt_mem[count[AW-1:0]] <= weight;
    end
    pos_rd <= pos_mem[rd_addr];
    wgt_rd <= wgt_mem[rd_addr];
  end
  assign rd_addr = idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_COLLECT;
      count   <= '0;
      sum_acc <= '0;
      total   <= '0;
      best_w  <= '0;
      best_x  <= '0;
      dropped <= 1'b0;
      valid   <= 1'b0;
      dv_go   <= 1'b0;
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
    end else begin
      valid <= 1'b0;
      dv_go <= 1'b0;
      unique case (state)
        ST_COLLECT: begin
          if (accept) begin
            if (store_ok) begin
              count   <= count + CW'(1);
              sum_acc <= sum_acc + SUMW'(xw);
              total   <= tot_add[TOTW] ? TOTAL_MAX : tot_add[TOTW-1:0];
              if (weight > best_w) begin
                best_w <= weight;
                best_x <= x_value;
              end
            end else begin
              dropped <= 1'b1;
            end
            if (last) begin
              state <= ST_MEAN;
            end
          end
        end
        ST_MEAN: begin
          // divide 2|s|+e by e
          e_den  <= (total == '0) ? TOTW'(1) : total;
          neg    <= sum_acc[SUMW-1];
          mag    <= sum_acc[SUMW-1] ? (~sum_acc + SUMW'(1)) : sum_acc;
          state  <= ST_MEANFIX;
          ph2    <= 1'b0;
        end
        ST_MEANFIX: begin
          if (!ph2) begin
            dv_num <= {{(SPW-SUMW-1){1'b0}}, mag, 1'b0} + SPW'(e_den);
            dv_den <= e_den;
            dv_go  <= 1'b1;
            ph2    <= 1'b1;
          end else if (dv_done) begin
            // quotient is twice the rounded value: halve, saturate
            if (neg) begin
              mean_r <= (dv_quo[SPW-1:1] > 63'd32768) ? 16'sh8000
                      : 16'(-$signed({1'b0, dv_quo[16:1]}));
            end else begin
              mean_r <= (dv_quo[SPW-1:1] > 63'd32767) ? 16'sh7fff
                      : 16'(dv_quo[16:1]);
            end
            idx    <= '0;
            spread <= '0;
            state  <= ST_SPREAD;
          end
        end
        ST_SPREAD: begin
          // issue one read a cycle; square and weigh in two stages behind it
          rd_vld <= (idx < count) && (idx < CW'(SLICE_DEPTH));
          if ((idx < count) && (idx < CW'(SLICE_DEPTH))) begin
            idx <= idx + CW'(1);
          end else begin
            state <= ST_SPDRAIN;
          end
        end
        ST_SPDRAIN: begin
          rd_vld <= 1'b0;
          if (!rd_vld && !mul_vld) begin
            dv_num <= spread;
            dv_den <= e_den;
            dv_go  <= 1'b1;
            state  <= ST_QDIV;
          end
        end
        ST_QDIV: begin
          if (dv_done) begin
            qv    <= dv_quo;
            root  <= '0;
            bitn  <= 6'd31;
            sub   <= 3'd0;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          // floor root one bit at a time: square, then compare
          if (sub == 3'd0) begin
            prod <= {32'd0, root | (32'd1 << bitn[4:0])} *
                    {32'd0, root | (32'd1 << bitn[4:0])};
            sub  <= 3'd1;
          end else begin
            if (prod <= qv) root <= root | (32'd1 << bitn[4:0]);
            sub <= 3'd0;
            if (bitn == 6'd0) begin
              state <= ST_ERRM;
              ph2   <= 1'b0;
            end
            bitn <= bitn - 6'd1;
          end
        end
        ST_ERRM, ST_ERRS: begin
          if (!ph2) begin
            // round sigma once, set up the 16-step root search
            if (state == ST_ERRM) begin
              sig <= (root >= 32'd65535) ? 17'd65535
                   : ((qv > 64'({16'd0, root[15:0]} * {16'd0, root[15:0]}) + 64'(root))
                      ? 17'(root + 32'd1) : 17'(root));
            end
            errr <= '0;
            bitn <= 6'd15;
            sub  <= 3'd0;
            ph2  <= 1'b1;
          end else begin
            unique case (sub)
              3'd0: begin
                prod <= 64'(errr | (16'd1 << bitn[3:0])) *
                        64'(errr | (16'd1 << bitn[3:0]));
                sub  <= 3'd1;
              end
              3'd1: begin
                prod2 <= prod[33:0] * ((state == ST_ERRS) ? {total, 1'b0} : {1'b0, total});
                prod  <= 64'(sig) * 64'(sig);
                sub   <= 3'd2;
              end
              3'd2: begin
                if (prod2 <= prod) errr <= errr | (16'd1 << bitn[3:0]);
                bitn <= bitn - 6'd1;
                sub  <= (bitn == 6'd0) ? 3'd3 : 3'd0;
              end
              3'd3: begin
                // tie-up rounding: (2r+1)^2*b <= 4a
                prod <= 64'({errr, 1'b1}) * 64'({errr, 1'b1});
                sub  <= 3'd4;
              end
              3'd4: begin
                prod2 <= prod[33:0] * ((state == ST_ERRS) ? {total, 1'b0} : {1'b0, total});
                prod  <= (64'(sig) * 64'(sig)) << 2;
                sub   <= 3'd5;
              end
              3'd5: begin
                // hold the rounded error until the result word goes out
                if (state == ST_ERRM) begin
                  mean_error <= (total == '0) ? 16'd0 :
                                ((prod2 <= prod) ? errr + 16'd1 : errr);
                end else begin
                  sigma_error <= (total == '0) ? 16'd0 :
                                 ((prod2 <= prod) ? errr + 16'd1 : errr);
                end
                ph2   <= 1'b0;
                state <= (state == ST_ERRM) ? ST_ERRS : ST_EMIT;
              end
              default: begin
                sub <= 3'd0;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (!ph2) begin
            ph2 <= 1'b1;
          end else begin
            valid        <= 1'b1;
            mean         <= (total == '0) ? 16'sd0 : mean_r;
            entries      <= total;
            peak_x       <= best_x;
            peak_y       <= best_w;
            weighted_sum <= sum_acc;
            empty_slice  <= (total == '0);
            overflow     <= dropped;
            sigma        <= (total == '0) ? 16'd0 : sig[15:0];
            count   <= '0;
            sum_acc <= '0;
            total   <= '0;
            best_w  <= '0;
            best_x  <= '0;
            dropped <= 1'b0;
            state   <= ST_COLLECT;
          end
        end
        default: state <= ST_COLLECT;
      endcase

      // spread pipeline: d^2 then times weight
      if (state == ST_SPREAD || state == ST_SPDRAIN) begin
        if (rd_vld) begin
          d2 <= 34'($signed({{2{pos_rd[XW-1]}}, pos_rd} - {{2{mean_r[15]}}, mean_r}) *
                    $signed({{2{pos_rd[XW-1]}}, pos_rd} - {{2{mean_r[15]}}, mean_r}));
          prod2 <= 64'(wgt_rd);
        end
        mul_vld <= rd_vld;
        if (mul_vld) spread <= spread + 64'(d2) * 64'(prod2[15:0]);
      end
    end
  end

endmodule

// File: sv/wss_checker.sv
// ----------------------------------------------------------------------------
// wss_checker: port-level checks of the weighted slice statistics core
// Watches handshake and result ports only.
// ----------------------------------------------------------------------------
module wss_checker
  import wss_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   last,
  input logic                   valid,
  input logic                   empty_slice,
  input logic [TOTW-1:0]        entries,
  input logic [15:0]            sigma,
  input logic [15:0]            mean_error
);

  // a last word must raise busy
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy) else $error("busy did not rise");

  // result only right after a busy cycle
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy)) else $error("result without busy period");

  // empty flag matches zero entries
  a_empty: assert property (@(posedge clk) disable iff (rst)
    valid |-> (empty_slice == (entries == '0))) else $error("empty flag wrong");

  // empty slice gives zero sigma and error
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && empty_slice) |-> (sigma == 16'd0 && mean_error == 16'd0))
    else $error("empty slice not zeroed");

  // never two results in a row
  a_single: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("double result");

endmodule

bind weighted_slice_statistics_core wss_checker u_wss_checker (
  .clk (clk), .rst (rst), .start (start), .busy (busy), .last (last),
  .valid (valid), .empty_slice (empty_slice), .entries (entries),
  .sigma (sigma), .mean_error (mean_error)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for weighted_slice_statistics_core
// Sends slices of (position, weight) words with random gaps, predicts each
// slice result in SystemVerilog, and compares every result word field by field.
// ----------------------------------------------------------------------------
module tb
  import wss_pkg::*;
();

  localparam int DEPTH      = 256;
  localparam int CYCLE_MAX  = 1500000;
  localparam int TAIL_WAIT  = 600;

  typedef struct {
    logic signed [15:0]     mean;
    logic [TOTW-1:0]        entries;
    logic signed [15:0]     peak_x;
    logic [15:0]            peak_y;
    logic [15:0]            sigma;
    logic signed [SUMW-1:0] weighted_sum;
    logic [15:0]            mean_error;
    logic [15:0]            sigma_error;
    logic                   empty_slice;
    logic                   overflow;
  } slice_stats_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic signed [XW-1:0]   x_value;
  logic [WW-1:0]          weight;
  logic                   last;
  logic                   valid;
  logic signed [15:0]     mean;
  logic [TOTW-1:0]        entries;
  logic signed [15:0]     peak_x;
  logic [15:0]            peak_y;
  logic [15:0]            sigma;
  logic signed [SUMW-1:0] weighted_sum;
  logic [15:0]            mean_error;
  logic [15:0]            sigma_error;
  logic                   empty_slice;
  logic                   overflow;

  weighted_slice_statistics_core #(.SLICE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_value(x_value), .weight(weight), .last(last), .valid(valid),
    .mean(mean), .entries(entries), .peak_x(peak_x), .peak_y(peak_y),
    .sigma(sigma), .weighted_sum(weighted_sum), .mean_error(mean_error),
    .sigma_error(sigma_error), .empty_slice(empty_slice), .overflow(overflow)
  );

  // Predictor copy of the slice state
  logic [15:0]     slice_pos [DEPTH];
  logic [15:0]     slice_wt [DEPTH];
  int              slice_pairs;
  logic [SUMW-1:0] slice_sum;
  logic [TOTW-1:0] slice_total;
  logic [15:0]     slice_best_w;
  logic [15:0]     slice_best_x;
  logic            slice_dropped;

  slice_stats_t stats_due[$];
  int errors;
  int words_sent;
  int slices_sent;
  int results_seen;
  longint cycles;
  bit steady;  // hold start high with no gaps

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] floor_root(logic [63:0] q);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= q) r = t;
    end
    return r;
  endfunction

  // nearest sqrt(a/b), ties up, clamp to 16 bits
  function automatic logic [15:0] nearest_root_ratio(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int k = 15; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t * b <= a) r = t;
    end
    t = 2 * r + 1;
    if (t * t * b <= 4 * a) r = r + 1;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic void clear_slice_state();
    slice_pairs   = 0;
    slice_sum     = '0;
    slice_total   = '0;
    slice_best_w  = '0;
    slice_best_x  = '0;
    slice_dropped = 1'b0;
  endfunction

  // Fold one accepted word into the slice; on last, queue the slice result.
  function automatic void fold_pair(logic [15:0] xr, logic [15:0] w, logic lst);
    longint       s;
    longint       m;
    longint       d;
    logic [63:0]  e;
    logic [63:0]  mag;
    logic [63:0]  spread;
    logic [63:0]  q;
    logic [63:0]  sig;
    logic [63:0]  tot;
    slice_stats_t res;
    if (slice_pairs < DEPTH) begin
      slice_pos[slice_pairs] = xr;
      slice_wt[slice_pairs]  = w;
      slice_pairs++;
      slice_sum = slice_sum + SUMW'(longint'($signed(xr)) * longint'(w));
      tot = 64'(slice_total) + 64'(w);
      slice_total = (tot > 64'(TOTAL_MAX)) ? TOTAL_MAX : tot[TOTW-1:0];
      if (w > slice_best_w) begin
        slice_best_w = w;
        slice_best_x = xr;
      end
    end else begin
      slice_dropped = 1'b1;
    end
    if (!lst) return;

    s   = longint'($signed(slice_sum));
    e   = (slice_total != 0) ? 64'(slice_total) : 64'd1;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    m   = longint'((2 * mag + e) / (2 * e));
    if (s < 0) m = -m;
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;

    // second pass over the stored pairs with the rounded mean
    spread = 0;
    for (int i = 0; i < slice_pairs; i++) begin
      d = longint'($signed(slice_pos[i])) - m;
      spread = spread + 64'(d * d) * 64'(slice_wt[i]);
    end
    q   = spread / e;
    sig = floor_root(q);
    if (q > sig * sig + sig) sig = sig + 1;
    if (sig > 65535) sig = 65535;

    res.mean         = 16'(m);
    res.entries      = slice_total;
    res.peak_x       = slice_best_x;
    res.peak_y       = slice_best_w;
    res.weighted_sum = slice_sum;
    res.overflow     = slice_dropped;
    if (slice_total == 0) begin
      res.mean        = '0;
      res.sigma       = '0;
      res.mean_error  = '0;
      res.sigma_error = '0;
      res.empty_slice = 1'b1;
    end else begin
      res.sigma       = sig[15:0];
      res.mean_error  = nearest_root_ratio(sig * sig, 64'(slice_total));
      res.sigma_error = nearest_root_ratio(sig * sig, 2 * 64'(slice_total));
      res.empty_slice = 1'b0;
    end
    stats_due.insert(stats_due.size(), res);
    slices_sent++;
    clear_slice_state();
  endfunction

  // Compare each result word against the oldest queued prediction.
  always @(posedge clk) begin
    slice_stats_t exp_s;
    if (!rst && valid) begin
      results_seen++;
      if (stats_due.size() == 0) begin
        $error("result word with no slice outstanding");
        errors++;
      end else begin
        exp_s = stats_due.pop_front();
        if (mean !== exp_s.mean) begin
          $error("mean exp %0d got %0d", exp_s.mean, mean); errors++;
        end
        if (entries !== exp_s.entries) begin
          $error("entries exp %0d got %0d", exp_s.entries, entries); errors++;
        end
        if (peak_x !== exp_s.peak_x) begin
          $error("peak_x exp %0d got %0d", exp_s.peak_x, peak_x); errors++;
        end
        if (peak_y !== exp_s.peak_y) begin
          $error("peak_y exp %0d got %0d", exp_s.peak_y, peak_y); errors++;
        end
        if (sigma !== exp_s.sigma) begin
          $error("sigma exp %0d got %0d", exp_s.sigma, sigma); errors++;
        end
        if (weighted_sum !== exp_s.weighted_sum) begin
          $error("weighted_sum exp %0d got %0d", exp_s.weighted_sum, weighted_sum);
          errors++;
        end
        if (mean_error !== exp_s.mean_error) begin
          $error("mean_error exp %0d got %0d", exp_s.mean_error, mean_error); errors++;
        end
        if (sigma_error !== exp_s.sigma_error) begin
          $error("sigma_error exp %0d got %0d", exp_s.sigma_error, sigma_error);
          errors++;
        end
        if (empty_slice !== exp_s.empty_slice) begin
          $error("empty_slice exp %0d got %0d", exp_s.empty_slice, empty_slice);
          errors++;
        end
        if (overflow !== exp_s.overflow) begin
          $error("overflow exp %0d got %0d", exp_s.overflow, overflow); errors++;
        end
      end
    end
  end

  // Mostly no gap, else short gaps, a few long ones, none while steady is set.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one word, hold it until accepted, then maybe drop start for a gap.
  task automatic send_word(logic [15:0] xr, logic [15:0] w, logic lst);
    int gap;
    start   <= 1'b1;
    x_value <= xr;
    weight  <= w;
    last    <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    fold_pair(xr, w, lst);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_weight();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return 16'd0;
    if (roll < 6) return 16'($urandom_range(1, 300));
    if (roll < 7) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_position(logic [15:0] centre);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return centre + 16'($urandom_range(0, 2047)) - 16'd1024;
  endfunction

  // Extremes of position and weight, negative and positive means.
  task automatic test_extremes();
    send_word(16'h8000, 16'hFFFF, 1'b1);
    send_word(16'h7FFF, 16'hFFFF, 1'b1);
    send_word(16'h8000, 16'd1, 1'b0);
    send_word(16'h7FFF, 16'd1, 1'b1);
    send_word(16'hFF80, 16'd3, 1'b0);
    send_word(16'hFE00, 16'd5, 1'b0);
    send_word(16'h0100, 16'd1, 1'b1);
  endtask

  // Total weight zero gives zeros and the empty flag.
  task automatic test_empty_slice();
    send_word(16'h1234, 16'd0, 1'b1);
    send_word(16'h8000, 16'd0, 1'b0);
    send_word(16'h7FFF, 16'd0, 1'b1);
  endtask

  // Equal weights: the first strictly largest keeps the peak.
  task automatic test_peak_ties();
    send_word(16'h0200, 16'd7, 1'b0);
    send_word(16'h0300, 16'd9, 1'b0);
    send_word(16'h0400, 16'd9, 1'b0);
    send_word(16'h0500, 16'd2, 1'b1);
  endtask

  // Fill past the buffer depth; dropped pairs set the flag, last still ends.
  task automatic test_buffer_full();
    for (int i = 0; i < DEPTH + 3; i++)
      send_word(16'($urandom), rand_weight(), i == DEPTH + 2);
    for (int i = 0; i < DEPTH; i++)
      send_word(16'($urandom), 16'hFFFF, i == DEPTH - 1);
  endtask

  // Random slices, mostly short; a few run past the buffer depth.
  task automatic test_random_slices(int word_budget);
    int          len;
    logic [15:0] centre;
    int          sent;
    sent = 0;
    while (sent < word_budget) begin
      steady = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 40) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 6)
                                         : $urandom_range(1, 12);
      centre = 16'($urandom);
      for (int i = 0; i < len; i++)
        send_word(rand_position(centre), rand_weight(), i == len - 1);
      sent += len;
      // Occasionally hold off until every pending slice result is back.
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    steady = 1'b0;
  endtask

  initial begin
    clk     = 1'b0;
    rst     = 1'b1;
    start   = 1'b0;
    x_value = '0;
    weight  = '0;
    last    = 1'b0;
    errors = 0; words_sent = 0; slices_sent = 0; results_seen = 0;
    cycles = 0;
    steady = 1'b0;
    clear_slice_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_empty_slice();
    test_peak_ties();
    drain_results();
    test_buffer_full();
    test_random_slices(1020);

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    $display("covered %0d words in %0d slices, %0d result words checked",
             words_sent, slices_sent, results_seen);
    $display("including empty slices, peak ties, extremes and dropped pairs");
    if (errors == 0 && stats_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
